// File: rtl/resource_graph_deadlock_detector_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the resource graph deadlock detector
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef RESOURCE_GRAPH_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH
`define RESOURCE_GRAPH_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RGDD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define RGDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rgdd_pkg.sv
// ---------------------------------------------------------------------------
// rgdd_pkg
// Types and constants shared by the deadlock detector controller, datapath
// and top level.
// ---------------------------------------------------------------------------
package rgdd_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int MAX_RESOURCES = 16;
	localparam int VERTEX_COUNT  = MAX_PROCESSES + MAX_RESOURCES;

	localparam int PROC_W  = 4;
	localparam int RES_W   = 4;
	localparam int COUNT_W = 5;
	localparam int CUR_W   = $clog2(MAX_RESOURCES + 1);
	localparam int SP_W    = $clog2(VERTEX_COUNT);
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_DETECT = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		command_t          command;
		logic [PROC_W-1:0] process_index;
		logic [RES_W-1:0]  resource_index;
	} item_t;

	typedef struct packed {
		status_t status;
		logic    request_recorded;
		logic    deadlock;
	} result_t;

	// graph vertex: a process or a resource
	typedef struct packed {
		logic             is_res;
		logic [RES_W-1:0] idx;
	} vertex_t;

	typedef struct packed {
		vertex_t          vtx;
		logic [CUR_W-1:0] cur;
	} frame_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_UPDATE,
		DP_CLEAR,
		DP_ROOT,
		DP_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   finish;
		logic   found;
	} dp_cmd_t;

	typedef struct packed {
		logic root_end;
		logic root_visited;
		logic found;
		logic tree_done;
	} dp_stat_t;

endpackage

// File: rtl/rgdd_ctrl.sv
// ---------------------------------------------------------------------------
// rgdd_ctrl
// Sequencer for the deadlock detector: takes commands, runs the depth-first
// walk one step per cycle and tells the datapath when to report.
// ---------------------------------------------------------------------------
`include "resource_graph_deadlock_detector_unit_defines.svh"

module rgdd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              is_detect,
	input  rgdd_pkg::dp_stat_t stat,
	output rgdd_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROOT,
		S_WALK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.op     = rgdd_pkg::DP_NONE;
		cmd.finish = 1'b0;
		cmd.found  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_detect) begin
						cmd.op  = rgdd_pkg::DP_CLEAR;
						state_d = S_ROOT;
					end else begin
						cmd.op = rgdd_pkg::DP_UPDATE;
					end
				end
			end
			S_ROOT: begin
				if (stat.root_end) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.op = rgdd_pkg::DP_ROOT;
					if (!stat.root_visited) begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				cmd.op = rgdd_pkg::DP_STEP;
				if (stat.found) begin
					// back edge onto the current path: cycle
					cmd.finish = 1'b1;
					cmd.found  = 1'b1;
					state_d    = S_IDLE;
				end else if (stat.tree_done) begin
					state_d = S_ROOT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`RGDD_ASSERT_NEXT(a_detect_starts_walk, accept && is_detect, state_q == S_ROOT, "detect did not start a walk")
	`RGDD_ASSERT_NEXT(a_finish_returns_idle, cmd.finish, state_q == S_IDLE, "walk did not end after report")

endmodule

// File: rtl/rgdd_datapath.sv
// ---------------------------------------------------------------------------
// rgdd_datapath
// Allocation tables, walk stack and marks, and the result register of the
// deadlock detector.
// ---------------------------------------------------------------------------
`include "resource_graph_deadlock_detector_unit_defines.svh"

module rgdd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rgdd_pkg::item_t                     item,
	input  rgdd_pkg::dp_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [rgdd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgdd_pkg::COUNT_W-1:0]        cfg_data,
	output rgdd_pkg::dp_stat_t                  stat,
	output logic                                done,
	output rgdd_pkg::result_t                   result
);

	logic [rgdd_pkg::COUNT_W-1:0] process_count_q;
	logic [rgdd_pkg::COUNT_W-1:0] resource_count_q;
	logic [rgdd_pkg::COUNT_W-1:0] pc;
	logic [rgdd_pkg::COUNT_W-1:0] rc;

	logic [rgdd_pkg::MAX_RESOURCES-1:0] holder_valid_q;
	logic [rgdd_pkg::PROC_W-1:0]        holder_proc_q [rgdd_pkg::MAX_RESOURCES];
	logic [rgdd_pkg::MAX_RESOURCES-1:0] request_q     [rgdd_pkg::MAX_PROCESSES];

	logic [rgdd_pkg::MAX_PROCESSES-1:0] visited_p_q;
	logic [rgdd_pkg::MAX_PROCESSES-1:0] onpath_p_q;
	logic [rgdd_pkg::MAX_RESOURCES-1:0] visited_r_q;
	logic [rgdd_pkg::MAX_RESOURCES-1:0] onpath_r_q;

	rgdd_pkg::frame_t              stack_q [rgdd_pkg::VERTEX_COUNT];
	logic [rgdd_pkg::SP_W-1:0]     sp_q;
	rgdd_pkg::vertex_t             top_vtx_q;
	logic [rgdd_pkg::CUR_W-1:0]    top_cur_q;
	logic [rgdd_pkg::COUNT_W-1:0]  root_q;

	logic                          done_q;
	rgdd_pkg::result_t             result_q;

	// update path
	logic [rgdd_pkg::PROC_W-1:0] up_p;
	logic [rgdd_pkg::RES_W-1:0]  up_r;
	logic                        in_range;
	logic                        do_grant;
	logic                        do_record;
	logic                        do_release;
	rgdd_pkg::result_t           up_result;

	// walk step
	logic [rgdd_pkg::MAX_RESOURCES-1:0] elig;
	logic                               has_succ;
	rgdd_pkg::vertex_t                  succ;
	logic [rgdd_pkg::CUR_W-1:0]         new_cur;
	logic                               succ_onpath;
	logic                               succ_visited;
	logic                               push;
	logic                               pop;
	logic                               step;

	assign pc = (process_count_q > rgdd_pkg::COUNT_W'(rgdd_pkg::MAX_PROCESSES)) ?
		rgdd_pkg::COUNT_W'(rgdd_pkg::MAX_PROCESSES) : process_count_q;
	assign rc = (resource_count_q > rgdd_pkg::COUNT_W'(rgdd_pkg::MAX_RESOURCES)) ?
		rgdd_pkg::COUNT_W'(rgdd_pkg::MAX_RESOURCES) : resource_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= rgdd_pkg::COUNT_W'(16);
			resource_count_q <= rgdd_pkg::COUNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				rgdd_pkg::CFG_PROCESS_COUNT:  process_count_q  <= cfg_data;
				rgdd_pkg::CFG_RESOURCE_COUNT: resource_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// get and free
	always_comb begin
		up_p       = item.process_index;
		up_r       = item.resource_index;
		in_range   = ({1'b0, up_p} < pc) && ({1'b0, up_r} < rc);
		do_grant   = 1'b0;
		do_record  = 1'b0;
		do_release = 1'b0;
		up_result  = '{status: rgdd_pkg::ST_OK, request_recorded: 1'b0, deadlock: 1'b0};
		case (item.command)
			rgdd_pkg::CMD_GET: begin
				if (!in_range) begin
					up_result.status = rgdd_pkg::ST_RANGE;
				end else if (holder_valid_q[up_r]) begin
					up_result.status = rgdd_pkg::ST_REFUSED;
					if (!request_q[up_p][up_r] && (holder_proc_q[up_r] != up_p)) begin
						do_record                  = 1'b1;
						up_result.request_recorded = 1'b1;
					end
				end else begin
					do_grant = 1'b1;
				end
			end
			rgdd_pkg::CMD_FREE: begin
				if (!in_range) begin
					up_result.status = rgdd_pkg::ST_RANGE;
				end else if (holder_valid_q[up_r] && (holder_proc_q[up_r] == up_p) &&
						(request_q[up_p] == '0)) begin
					do_release = 1'b1;
				end else begin
					up_result.status = rgdd_pkg::ST_REFUSED;
				end
			end
			rgdd_pkg::CMD_DETECT: ;
			default: begin
				up_result.status = rgdd_pkg::ST_REFUSED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_valid_q <= '0;
			for (int i = 0; i < rgdd_pkg::MAX_PROCESSES; i++) begin
				request_q[i] <= '0;
			end
		end else if (cmd.op == rgdd_pkg::DP_UPDATE) begin
			if (do_grant) begin
				holder_valid_q[up_r] <= 1'b1;
				request_q[up_p][up_r] <= 1'b0;
			end
			if (do_record) begin
				request_q[up_p][up_r] <= 1'b1;
			end
			if (do_release) begin
				holder_valid_q[up_r] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == rgdd_pkg::DP_UPDATE) && do_grant) begin
			holder_proc_q[up_r] <= up_p;
		end
	end

	// successor of the top vertex from its cursor
	always_comb begin
		for (int i = 0; i < rgdd_pkg::MAX_RESOURCES; i++) begin
			elig[i] = request_q[top_vtx_q.idx][i] &&
				(rgdd_pkg::COUNT_W'(i) < rc) && (rgdd_pkg::CUR_W'(i) >= top_cur_q);
		end
		has_succ = 1'b0;
		succ     = '0;
		new_cur  = top_cur_q;
		if (!top_vtx_q.is_res) begin
			for (int i = rgdd_pkg::MAX_RESOURCES - 1; i >= 0; i--) begin
				if (elig[i]) begin
					has_succ = 1'b1;
					succ     = '{is_res: 1'b1, idx: rgdd_pkg::RES_W'(i)};
					new_cur  = rgdd_pkg::CUR_W'(i) + rgdd_pkg::CUR_W'(1);
				end
			end
		end else if ((top_cur_q == '0) && holder_valid_q[top_vtx_q.idx] &&
				({1'b0, holder_proc_q[top_vtx_q.idx]} < pc)) begin
			has_succ = 1'b1;
			succ     = '{is_res: 1'b0, idx: holder_proc_q[top_vtx_q.idx]};
			new_cur  = rgdd_pkg::CUR_W'(1);
		end
		succ_onpath  = succ.is_res ? onpath_r_q[succ.idx]  : onpath_p_q[succ.idx];
		succ_visited = succ.is_res ? visited_r_q[succ.idx] : visited_p_q[succ.idx];
	end

	assign step = (cmd.op == rgdd_pkg::DP_STEP);
	assign pop  = !has_succ;
	assign push = has_succ && !succ_onpath && !succ_visited;

	assign stat.root_end     = (root_q >= pc);
	assign stat.root_visited = visited_p_q[root_q[rgdd_pkg::PROC_W-1:0]];
	assign stat.found        = has_succ && succ_onpath;
	assign stat.tree_done    = pop && (sp_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_p_q <= '0;
			onpath_p_q  <= '0;
			visited_r_q <= '0;
			onpath_r_q  <= '0;
			sp_q        <= '0;
			root_q      <= '0;
		end else begin
			case (cmd.op)
				rgdd_pkg::DP_CLEAR: begin
					visited_p_q <= '0;
					onpath_p_q  <= '0;
					visited_r_q <= '0;
					onpath_r_q  <= '0;
					sp_q        <= '0;
					root_q      <= '0;
				end
				rgdd_pkg::DP_ROOT: begin
					if (visited_p_q[root_q[rgdd_pkg::PROC_W-1:0]]) begin
						root_q <= root_q + rgdd_pkg::COUNT_W'(1);
					end else begin
						visited_p_q[root_q[rgdd_pkg::PROC_W-1:0]] <= 1'b1;
						onpath_p_q[root_q[rgdd_pkg::PROC_W-1:0]]  <= 1'b1;
						sp_q <= '0;
					end
				end
				rgdd_pkg::DP_STEP: begin
					if (pop) begin
						if (top_vtx_q.is_res) begin
							onpath_r_q[top_vtx_q.idx] <= 1'b0;
						end else begin
							onpath_p_q[top_vtx_q.idx] <= 1'b0;
						end
						if (sp_q == '0) begin
							root_q <= root_q + rgdd_pkg::COUNT_W'(1);
						end else begin
							sp_q <= sp_q - rgdd_pkg::SP_W'(1);
						end
					end else if (push) begin
						if (succ.is_res) begin
							visited_r_q[succ.idx] <= 1'b1;
							onpath_r_q[succ.idx]  <= 1'b1;
						end else begin
							visited_p_q[succ.idx] <= 1'b1;
							onpath_p_q[succ.idx]  <= 1'b1;
						end
						sp_q <= sp_q + rgdd_pkg::SP_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// top of the walk and the frames beneath it
	always_ff @(posedge clk) begin
		if ((cmd.op == rgdd_pkg::DP_ROOT) && !visited_p_q[root_q[rgdd_pkg::PROC_W-1:0]]) begin
			top_vtx_q <= '{is_res: 1'b0, idx: root_q[rgdd_pkg::PROC_W-1:0]};
			top_cur_q <= '0;
		end else if (step) begin
			if (pop) begin
				if (sp_q != '0) begin
					top_vtx_q <= stack_q[sp_q - rgdd_pkg::SP_W'(1)].vtx;
					top_cur_q <= stack_q[sp_q - rgdd_pkg::SP_W'(1)].cur;
				end
			end else if (push) begin
				stack_q[sp_q] <= '{vtx: top_vtx_q, cur: new_cur};
				top_vtx_q     <= succ;
				top_cur_q     <= '0;
			end else begin
				top_cur_q <= new_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == rgdd_pkg::DP_UPDATE) || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rgdd_pkg::DP_UPDATE) begin
			result_q <= up_result;
		end else if (cmd.finish) begin
			result_q <= '{status: rgdd_pkg::ST_OK, request_recorded: 1'b0, deadlock: cmd.found};
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`RGDD_ASSERT(a_stack_no_overflow, !(step && push) || (sp_q != '1), "walk stack overflow")
	`RGDD_ASSERT(a_path_marks_visited, ((onpath_p_q & ~visited_p_q) == '0) && ((onpath_r_q & ~visited_r_q) == '0), "path mark without visit mark")
	`RGDD_ASSERT(a_done_has_source, !done_q || $past((cmd.op == rgdd_pkg::DP_UPDATE) || cmd.finish), "result strobe without a source")

endmodule

// File: rtl/resource_graph_deadlock_detector_unit.sv
// ---------------------------------------------------------------------------
// resource_graph_deadlock_detector_unit
// Single-instance resource allocation graph with cycle (deadlock) detection.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the item is taken at a clock
//   edge with start high and busy low. Commands: get, free, detect.
//   Result channel: done is high for one cycle with result valid; the
//   receiver cannot stall, so every result must be taken in that cycle.
//   Configuration: cfg_we, cfg_index, cfg_data write the process or resource
//   count that cfg_index selects; write only while the block is idle.
// Command flow:
//   get, free and the unused code finish with done registered in the cycle
//   after acceptance and may be issued every cycle; busy stays low.
//   detect raises busy while it probes each root, examines each edge and
//   retires each vertex, plus a closing probe when no cycle is found. done
//   is high in the first cycle with busy low.
// Reset: all resources free, no requests, both counts 16, no walk pending.
// ---------------------------------------------------------------------------
module resource_graph_deadlock_detector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  rgdd_pkg::item_t                item,
	output logic                           busy,
	output logic                           done,
	output rgdd_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [rgdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgdd_pkg::COUNT_W-1:0]   cfg_data
);

	rgdd_pkg::dp_cmd_t  cmd;
	rgdd_pkg::dp_stat_t stat;
	logic               is_detect;

	assign is_detect = (item.command == rgdd_pkg::CMD_DETECT);

	rgdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.is_detect (is_detect),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	rgdd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule

// File: test/tb_resource_graph_deadlock_detector_unit.sv
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// tb_resource_graph_deadlock_detector_unit
// Drives get, free, detect and the unused command code through the command
// port and checks each result against a model of the allocation graph. The
// model tracks resource holders and per-process request bitmaps, and it
// searches for cycles. Both counts are rewritten between phases: zero,
// clamped, shrunk below live entries, and random sizes.
// ---------------------------------------------------------------------------

import rgdd_pkg::*;

localparam logic [1:0] CMD_UNUSED = 2'd3;

class graph_tracker;
	int unsigned proc_setting = 16;
	int unsigned res_setting  = 16;
	bit held [MAX_RESOURCES];
	int unsigned holder [MAX_RESOURCES];
	bit [MAX_RESOURCES-1:0] wait_bits [MAX_PROCESSES];
	result_t due_results [$];
	int unsigned faults;
	int unsigned detects;
	int unsigned cycles_seen;

	function void set_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
		if (idx == CFG_PROCESS_COUNT) begin
			proc_setting = 32'(value);
		end else begin
			res_setting = 32'(value);
		end
	endfunction

	function int unsigned live_procs();
		return proc_setting < MAX_PROCESSES ? proc_setting : MAX_PROCESSES;
	endfunction

	function int unsigned live_res();
		return res_setting < MAX_RESOURCES ? res_setting : MAX_RESOURCES;
	endfunction

	// vertices: processes 0..pc-1, then resources pc..pc+rc-1
	function bit graph_has_cycle(int unsigned pc, int unsigned rc);
		bit seen [VERTEX_COUNT];
		bit on_path [VERTEX_COUNT];
		int unsigned stack [VERTEX_COUNT];
		int unsigned cursor [VERTEX_COUNT];
		int unsigned sp, v, r;
		int w;
		for (int i = 0; i < VERTEX_COUNT; i++) begin
			seen[i] = 0;
			on_path[i] = 0;
			cursor[i] = 0;
		end
		for (int unsigned s = 0; s < pc + rc; s++) begin
			if (!seen[s]) begin
				seen[s] = 1;
				on_path[s] = 1;
				stack[0] = s;
				sp = 1;
				while (sp > 0) begin
					v = stack[sp-1];
					w = -1;
					if (v < pc) begin
						while (w < 0 && cursor[v] < rc) begin
							r = cursor[v];
							cursor[v]++;
							if (wait_bits[v][r])
								w = int'(pc + r);
						end
					end else begin
						r = v - pc;
						if (cursor[v] == 0) begin
							cursor[v] = 1;
							if (held[r] && holder[r] < pc)
								w = int'(holder[r]);
						end
					end
					if (w < 0) begin
						on_path[v] = 0;
						sp--;
					end else if (on_path[w]) begin
						return 1;
					end else if (!seen[w] && sp < VERTEX_COUNT) begin
						seen[w] = 1;
						on_path[w] = 1;
						stack[sp] = w;
						sp++;
					end
				end
			end
		end
		return 0;
	endfunction

	function void apply_item(item_t it);
		int unsigned pc, rc, p, r;
		result_t res;
		pc = live_procs();
		rc = live_res();
		p = 32'(it.process_index);
		r = 32'(it.resource_index);
		res = '0;
		res.status = ST_OK;
		if (it.command == CMD_DETECT) begin
			res.deadlock = graph_has_cycle(pc, rc);
			detects++;
			if (res.deadlock)
				cycles_seen++;
		end else if (it.command == CMD_UNUSED) begin
			res.status = ST_REFUSED;
		end else if (p >= pc || r >= rc) begin
			res.status = ST_RANGE;
		end else if (it.command == CMD_GET) begin
			if (held[r]) begin
				res.status = ST_REFUSED;
				if (!wait_bits[p][r] && holder[r] != p) begin
					wait_bits[p][r] = 1;
					res.request_recorded = 1;
				end
			end else begin
				wait_bits[p][r] = 0;
				held[r] = 1;
				holder[r] = p;
			end
		end else begin
			if (held[r] && holder[r] == p && wait_bits[p] == '0)
				held[r] = 0;
			else
				res.status = ST_REFUSED;
		end
		due_results = {due_results, res};
	endfunction

	function void compare_result(result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result, got %b", $time, got);
			faults++;
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
			faults++;
		end
		if (got.request_recorded !== want.request_recorded) begin
			$display("%0t: request_recorded expected %b, got %b", $time,
				want.request_recorded, got.request_recorded);
			faults++;
		end
		if (got.deadlock !== want.deadlock) begin
			$display("%0t: deadlock expected %b, got %b", $time, want.deadlock, got.deadlock);
			faults++;
		end
	endfunction
endclass

module tb_resource_graph_deadlock_detector_unit;
	localparam int GAP_MAX     = 6;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0] cfg_data = '0;

	graph_tracker tracker;
	int unsigned stall_cycles;
	int unsigned items_sent;
	int unsigned count_settings;
	bit burst;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	resource_graph_deadlock_detector_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// check results; end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.compare_result(result);
		if (!arst_n || done || (start && !busy))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// hold start high until the item is taken; keep it high for a back-to-back item
	task automatic issue(logic [1:0] cmd, logic [3:0] p, logic [3:0] r);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= item_t'({cmd, p, r});
		do @(posedge clk); while (busy);
		tracker.apply_item(item);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_counts(logic [COUNT_W-1:0] procs, logic [COUNT_W-1:0] res);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROCESS_COUNT;
		cfg_data <= procs;
		@(posedge clk);
		tracker.set_count(CFG_PROCESS_COUNT, procs);
		cfg_index <= CFG_RESOURCE_COUNT;
		cfg_data <= res;
		@(posedge clk);
		tracker.set_count(CFG_RESOURCE_COUNT, res);
		cfg_we <= 1'b0;
		count_settings++;
	endtask

	// mostly in-range traffic on the live part of the graph, some range errors
	task automatic random_phase(int unsigned n);
		int unsigned pc, rc, pick;
		logic [1:0] cmd;
		logic [3:0] p, r;
		pc = tracker.live_procs();
		rc = tracker.live_res();
		burst = ($urandom_range(0, 3) == 0);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0)
				burst = !burst;
			pick = $urandom_range(0, 99);
			p = (pc > 0) ? 4'($urandom_range(0, pc - 1)) : 4'($urandom_range(0, 15));
			r = (rc > 0) ? 4'($urandom_range(0, rc - 1)) : 4'($urandom_range(0, 15));
			if (pick < 50) begin
				cmd = CMD_GET;
			end else if (pick < 80) begin
				cmd = CMD_FREE;
			end else if (pick < 92) begin
				cmd = CMD_DETECT;
			end else if (pick < 95) begin
				cmd = CMD_UNUSED;
			end else begin
				cmd = $urandom_range(0, 1) ? CMD_FREE : CMD_GET;
				p = 4'($urandom_range(0, 15));
				r = 4'($urandom_range(0, 15));
			end
			issue(cmd, p, r);
		end
	endtask

	initial begin
		tracker = new();
		burst = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// grant, request, repeat request, re-get by holder, refused and good frees
		issue(CMD_GET, 4'd0, 4'd0);
		issue(CMD_GET, 4'd1, 4'd0);
		issue(CMD_GET, 4'd1, 4'd0);
		issue(CMD_GET, 4'd0, 4'd0);
		issue(CMD_FREE, 4'd1, 4'd0);
		issue(CMD_GET, 4'd1, 4'd1);
		issue(CMD_FREE, 4'd1, 4'd1);
		issue(CMD_FREE, 4'd0, 4'd0);
		issue(CMD_GET, 4'd1, 4'd0);
		issue(CMD_FREE, 4'd1, 4'd1);
		issue(CMD_DETECT, 4'd0, 4'd0);
		// two-process cycle on the top indices
		issue(CMD_GET, 4'd15, 4'd15);
		issue(CMD_GET, 4'd14, 4'd14);
		issue(CMD_GET, 4'd15, 4'd14);
		issue(CMD_GET, 4'd14, 4'd15);
		issue(CMD_DETECT, 4'd15, 4'd15);
		issue(CMD_FREE, 4'd15, 4'd15);
		issue(CMD_UNUSED, 4'd15, 4'd15);
		settle();

		// shrunk counts hide the cycle and reject the top indices
		set_counts(5'd14, 5'd14);
		issue(CMD_DETECT, 4'd0, 4'd0);
		issue(CMD_GET, 4'd14, 4'd0);
		issue(CMD_GET, 4'd0, 4'd14);
		settle();

		set_counts(5'd0, 5'd0);
		issue(CMD_GET, 4'd0, 4'd0);
		issue(CMD_FREE, 4'd0, 4'd0);
		issue(CMD_DETECT, 4'd0, 4'd0);
		settle();

		// values above the maximum clamp to it
		set_counts(5'd31, 5'd31);
		issue(CMD_DETECT, 4'd0, 4'd0);
		settle();

		// keep the fixed cycle out of view in most phases
		set_counts(5'd4, 5'd3);
		random_phase(100);
		settle();
		set_counts(5'd2, 5'd17);
		random_phase(80);
		settle();
		set_counts(5'd31, 5'd1);
		random_phase(60);
		settle();
		set_counts(5'd13, 5'd16);
		random_phase(100);
		settle();
		set_counts(COUNT_W'($urandom_range(1, 31)), COUNT_W'($urandom_range(1, 31)));
		random_phase(80);
		settle();
		set_counts(5'd6, 5'd6);
		random_phase(80);

		start <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d items under %0d count settings, with bursts and idle gaps.",
			items_sent, count_settings);
		$display("Issued %0d detects, %0d of them on a graph with a cycle.",
			tracker.detects, tracker.cycles_seen);
		if (tracker.faults == 0 && tracker.due_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d field errors, %0d results never arrived", tracker.faults,
				tracker.due_results.size());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rgdd_pkg.sv
rtl/rgdd_ctrl.sv
rtl/rgdd_datapath.sv
rtl/resource_graph_deadlock_detector_unit.sv
test/tb_resource_graph_deadlock_detector_unit.sv
